@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the log ring RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

`endif

@@ rtl/core/lrfq_pkg.sv @@
// Types, constants and pointer helpers for the log ring buffer.
package lrfq_pkg;

    localparam int DEPTH         = 16;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int SIZE_W        = PTR_W + 1;
    localparam int RSIZE_W       = 5;
    localparam int CMP_W         = (RSIZE_W > SIZE_W) ? RSIZE_W : SIZE_W;
    localparam int RING_SIZE_RST = 16;
    localparam int CFG_DATA_W    = 5;
    localparam int CFG_IDX_W     = 1;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 3;
    localparam int STAMP_W  = 32;
    localparam int LINE_W   = 16;
    localparam int HANDLE_W = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_CLR = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 2'd0,
        STS_REFUSED = 2'd1,
        STS_DROPPED = 2'd2,
        STS_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DROP_OLDEST = 1'b0,
        CFG_RING_SIZE   = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_READ = 1'b1
    } fsm_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [STAMP_W-1:0]  stamp;
        logic [LINE_W-1:0]   line;
        logic [HANDLE_W-1:0] text;
        logic [HANDLE_W-1:0] func;
        logic [HANDLE_W-1:0] label;
    } record_t;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] addr;
        record_t          rec;
    } store_wr_t;

    typedef struct packed {
        logic             re;
        logic [PTR_W-1:0] addr;
    } store_rd_t;

    // Ring size clamped to [2, DEPTH].
    function automatic logic [SIZE_W-1:0] eff_size(logic [RSIZE_W-1:0] rs);
        logic [CMP_W-1:0] s;
        s = CMP_W'(rs);
        if (s < CMP_W'(2)) s = CMP_W'(2);
        if (s > CMP_W'(DEPTH)) s = CMP_W'(DEPTH);
        return SIZE_W'(s);
    endfunction

    // Next slot; wraps to zero at or past the ring size.
    function automatic logic [PTR_W-1:0] succ(logic [PTR_W-1:0] p,
                                              logic [SIZE_W-1:0] eff);
        logic [SIZE_W-1:0] n;
        n = SIZE_W'(p) + SIZE_W'(1);
        return (n >= eff) ? '0 : n[PTR_W-1:0];
    endfunction

endpackage

@@ rtl/core/lrfq_store.sv @@
// Record storage: one synchronous memory per field, per-entry valid bits.
`include "assert_macros.svh"

module lrfq_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  lrfq_pkg::store_wr_t wr,
    input  lrfq_pkg::store_rd_t rd,
    output lrfq_pkg::record_t   rd_rec
);

    logic [lrfq_pkg::LEVEL_W-1:0]  level_mem [lrfq_pkg::DEPTH];
    logic [lrfq_pkg::STAMP_W-1:0]  stamp_mem [lrfq_pkg::DEPTH];
    logic [lrfq_pkg::LINE_W-1:0]   line_mem  [lrfq_pkg::DEPTH];
    logic [lrfq_pkg::HANDLE_W-1:0] text_mem  [lrfq_pkg::DEPTH];
    logic [lrfq_pkg::HANDLE_W-1:0] func_mem  [lrfq_pkg::DEPTH];
    logic [lrfq_pkg::HANDLE_W-1:0] label_mem [lrfq_pkg::DEPTH];

    // Unwritten entries read as zero.
    logic [lrfq_pkg::DEPTH-1:0] vld_ls_reg;
    logic [lrfq_pkg::DEPTH-1:0] vld_line_reg;
    logic [lrfq_pkg::DEPTH-1:0] vld_text_reg;
    logic [lrfq_pkg::DEPTH-1:0] vld_func_reg;
    logic [lrfq_pkg::DEPTH-1:0] vld_label_reg;

    lrfq_pkg::record_t rd_q_reg;
    logic              rd_ls_reg;
    logic              rd_line_reg;
    logic              rd_text_reg;
    logic              rd_func_reg;
    logic              rd_label_reg;

    logic wr_line;
    logic wr_text;
    logic wr_func;
    logic wr_label;

    assign wr_line  = wr.we && (wr.rec.line  != '0);
    assign wr_text  = wr.we && (wr.rec.text  != '0);
    assign wr_func  = wr.we && (wr.rec.func  != '0);
    assign wr_label = wr.we && (wr.rec.label != '0);

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            level_mem[wr.addr] <= wr.rec.level;
            stamp_mem[wr.addr] <= wr.rec.stamp;
        end
        if (wr_line)  line_mem[wr.addr]  <= wr.rec.line;
        if (wr_text)  text_mem[wr.addr]  <= wr.rec.text;
        if (wr_func)  func_mem[wr.addr]  <= wr.rec.func;
        if (wr_label) label_mem[wr.addr] <= wr.rec.label;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_ls_reg    <= '0;
            vld_line_reg  <= '0;
            vld_text_reg  <= '0;
            vld_func_reg  <= '0;
            vld_label_reg <= '0;
        end else begin
            if (wr.we)    vld_ls_reg[wr.addr]    <= 1'b1;
            if (wr_line)  vld_line_reg[wr.addr]  <= 1'b1;
            if (wr_text)  vld_text_reg[wr.addr]  <= 1'b1;
            if (wr_func)  vld_func_reg[wr.addr]  <= 1'b1;
            if (wr_label) vld_label_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.re) begin
            rd_q_reg.level <= level_mem[rd.addr];
            rd_q_reg.stamp <= stamp_mem[rd.addr];
            rd_q_reg.line  <= line_mem[rd.addr];
            rd_q_reg.text  <= text_mem[rd.addr];
            rd_q_reg.func  <= func_mem[rd.addr];
            rd_q_reg.label <= label_mem[rd.addr];
            rd_ls_reg      <= vld_ls_reg[rd.addr];
            rd_line_reg    <= vld_line_reg[rd.addr];
            rd_text_reg    <= vld_text_reg[rd.addr];
            rd_func_reg    <= vld_func_reg[rd.addr];
            rd_label_reg   <= vld_label_reg[rd.addr];
        end
    end

    always_comb begin
        rd_rec.level = rd_ls_reg    ? rd_q_reg.level : '0;
        rd_rec.stamp = rd_ls_reg    ? rd_q_reg.stamp : '0;
        rd_rec.line  = rd_line_reg  ? rd_q_reg.line  : '0;
        rd_rec.text  = rd_text_reg  ? rd_q_reg.text  : '0;
        rd_rec.func  = rd_func_reg  ? rd_q_reg.func  : '0;
        rd_rec.label = rd_label_reg ? rd_q_reg.label : '0;
    end

    `ASSERT_NEVER(a_no_rd_wr_overlap, wr.we && rd.re, "read and write in the same cycle")
    `ASSERT_RST(a_wr_marks_valid, wr.we |=> vld_ls_reg[$past(wr.addr)], "written slot not valid")
    `ASSERT_RST(a_line_marks_valid, wr_line |=> vld_line_reg[$past(wr.addr)], "line not valid")

endmodule

@@ rtl/core/log_ring_fifo_drop_policy_core.sv @@
// Top level of the log record ring buffer with full-ring drop policy.
// Each transaction on the s_ channel carries one opcode and returns exactly one
// transaction on the m_ channel. Enqueue, clear and unused opcodes write the
// result register directly; a dequeue of a non-empty ring goes through the read
// state, because the record comes from the synchronous record memories. A new
// item is accepted while the block is idle and the result register is empty or
// being taken in the same cycle. Configuration writes take effect at the clock
// edge of the write and are meant to be made while the block is idle.
`include "assert_macros.svh"

module log_ring_fifo_drop_policy_core (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [lrfq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lrfq_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lrfq_pkg::OPCODE_W-1:0]     s_opcode,
    input  logic [lrfq_pkg::LEVEL_W-1:0]      s_in_level,
    input  logic [lrfq_pkg::STAMP_W-1:0]      s_in_stamp,
    input  logic [lrfq_pkg::LINE_W-1:0]       s_in_line,
    input  logic [lrfq_pkg::HANDLE_W-1:0]     s_in_text,
    input  logic [lrfq_pkg::HANDLE_W-1:0]     s_in_func,
    input  logic [lrfq_pkg::HANDLE_W-1:0]     s_in_label,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lrfq_pkg::STATUS_W-1:0]     m_status,
    output logic [lrfq_pkg::LEVEL_W-1:0]      m_out_level,
    output logic [lrfq_pkg::STAMP_W-1:0]      m_out_stamp,
    output logic [lrfq_pkg::LINE_W-1:0]       m_out_line,
    output logic [lrfq_pkg::HANDLE_W-1:0]     m_out_text,
    output logic [lrfq_pkg::HANDLE_W-1:0]     m_out_func,
    output logic [lrfq_pkg::HANDLE_W-1:0]     m_out_label,
    output logic                              m_is_full,
    output logic                              m_is_empty
);

    logic                           drop_oldest_reg;
    logic [lrfq_pkg::RSIZE_W-1:0]   ring_size_reg;
    logic [lrfq_pkg::SIZE_W-1:0]    eff;

    lrfq_pkg::fsm_t                 state_reg, state_next;
    logic [lrfq_pkg::PTR_W-1:0]     head_reg, head_next;
    logic [lrfq_pkg::PTR_W-1:0]     tail_reg, tail_next;

    logic                           m_valid_reg, m_valid_next;
    lrfq_pkg::status_t              status_reg, status_next;
    lrfq_pkg::record_t              out_rec_reg, out_rec_next;
    logic                           full_reg, full_next;
    logic                           empty_reg, empty_next;

    lrfq_pkg::store_wr_t            wr;
    lrfq_pkg::store_rd_t            rd;
    lrfq_pkg::record_t              rd_rec;

    logic                           accept;
    logic                           ring_full;

    lrfq_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd      (rd),
        .rd_rec  (rd_rec)
    );

    assign eff       = lrfq_pkg::eff_size(ring_size_reg);
    assign s_ready   = (state_reg == lrfq_pkg::FSM_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign ring_full = (lrfq_pkg::succ(tail_reg, eff) == head_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_oldest_reg <= 1'b0;
            ring_size_reg   <= lrfq_pkg::RSIZE_W'(lrfq_pkg::RING_SIZE_RST);
            state_reg       <= lrfq_pkg::FSM_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    lrfq_pkg::CFG_DROP_OLDEST: drop_oldest_reg <= cfg_data[0];
                    lrfq_pkg::CFG_RING_SIZE:   ring_size_reg   <= cfg_data;
                    default: ;
                endcase
            end
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        out_rec_reg <= out_rec_next;
        full_reg    <= full_next;
        empty_reg   <= empty_next;
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        out_rec_next = out_rec_reg;
        full_next    = full_reg;
        empty_next   = empty_reg;

        wr.we        = 1'b0;
        wr.addr      = tail_reg;
        wr.rec.level = s_in_level;
        wr.rec.stamp = s_in_stamp;
        wr.rec.line  = s_in_line;
        wr.rec.text  = s_in_text;
        wr.rec.func  = s_in_func;
        wr.rec.label = s_in_label;
        rd.re        = 1'b0;
        rd.addr      = head_reg;

        case (state_reg)
            lrfq_pkg::FSM_IDLE: begin
                if (accept) begin
                    status_next  = lrfq_pkg::STS_OK;
                    out_rec_next = '0;
                    m_valid_next = 1'b1;
                    case (s_opcode)
                        lrfq_pkg::OP_ENQ: begin
                            if (ring_full && !drop_oldest_reg) begin
                                status_next = lrfq_pkg::STS_REFUSED;
                            end else begin
                                if (ring_full) begin
                                    head_next   = lrfq_pkg::succ(head_reg, eff);
                                    status_next = lrfq_pkg::STS_DROPPED;
                                end
                                wr.we     = 1'b1;
                                tail_next = lrfq_pkg::succ(tail_reg, eff);
                            end
                        end
                        lrfq_pkg::OP_DEQ: begin
                            if (head_reg == tail_reg) begin
                                status_next = lrfq_pkg::STS_EMPTY;
                            end else begin
                                // store reads the record; the read state loads it
                                rd.re        = 1'b1;
                                head_next    = lrfq_pkg::succ(head_reg, eff);
                                state_next   = lrfq_pkg::FSM_READ;
                                m_valid_next = 1'b0;
                            end
                        end
                        lrfq_pkg::OP_CLR: begin
                            head_next = tail_reg;
                        end
                        default: ;
                    endcase
                    full_next  = (lrfq_pkg::succ(tail_next, eff) == head_next);
                    empty_next = (head_next == tail_next);
                end
            end
            lrfq_pkg::FSM_READ: begin
                out_rec_next = rd_rec;
                m_valid_next = 1'b1;
                state_next   = lrfq_pkg::FSM_IDLE;
            end
            default: begin
                state_next = lrfq_pkg::FSM_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_out_level = out_rec_reg.level;
    assign m_out_stamp = out_rec_reg.stamp;
    assign m_out_line  = out_rec_reg.line;
    assign m_out_text  = out_rec_reg.text;
    assign m_out_func  = out_rec_reg.func;
    assign m_out_label = out_rec_reg.label;
    assign m_is_full   = full_reg;
    assign m_is_empty  = empty_reg;

    `ASSERT_RST(a_read_slot_free, state_reg == lrfq_pkg::FSM_READ |-> !m_valid_reg, "result busy in read")
    `ASSERT_RST(a_read_one_cycle, state_reg == lrfq_pkg::FSM_READ |=> state_reg == lrfq_pkg::FSM_IDLE && m_valid_reg, "read did not finish")
    `ASSERT_RST(a_deq_reads, accept && s_opcode == lrfq_pkg::OP_DEQ && head_reg != tail_reg |=> state_reg == lrfq_pkg::FSM_READ, "dequeue skipped read")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the log record ring buffer with full-ring drop policy.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lrfq_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 146;

    typedef struct {
        logic [lrfq_pkg::OPCODE_W-1:0] opcode;
        logic [lrfq_pkg::LEVEL_W-1:0]  level;
        logic [lrfq_pkg::STAMP_W-1:0]  stamp;
        logic [lrfq_pkg::LINE_W-1:0]   line;
        logic [lrfq_pkg::HANDLE_W-1:0] text;
        logic [lrfq_pkg::HANDLE_W-1:0] func;
        logic [lrfq_pkg::HANDLE_W-1:0] label;
    } log_entry_t;

    typedef struct {
        lrfq_pkg::status_t             status;
        logic [lrfq_pkg::LEVEL_W-1:0]  level;
        logic [lrfq_pkg::STAMP_W-1:0]  stamp;
        logic [lrfq_pkg::LINE_W-1:0]   line;
        logic [lrfq_pkg::HANDLE_W-1:0] text;
        logic [lrfq_pkg::HANDLE_W-1:0] func;
        logic [lrfq_pkg::HANDLE_W-1:0] label;
        logic                          full;
        logic                          empty;
    } log_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                            cfg_wr_en = 1'b0;
    logic [lrfq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lrfq_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                          s_valid    = 1'b0;
    logic                          s_ready;
    logic [lrfq_pkg::OPCODE_W-1:0] s_opcode   = '0;
    logic [lrfq_pkg::LEVEL_W-1:0]  s_in_level = '0;
    logic [lrfq_pkg::STAMP_W-1:0]  s_in_stamp = '0;
    logic [lrfq_pkg::LINE_W-1:0]   s_in_line  = '0;
    logic [lrfq_pkg::HANDLE_W-1:0] s_in_text  = '0;
    logic [lrfq_pkg::HANDLE_W-1:0] s_in_func  = '0;
    logic [lrfq_pkg::HANDLE_W-1:0] s_in_label = '0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [lrfq_pkg::STATUS_W-1:0] m_status;
    logic [lrfq_pkg::LEVEL_W-1:0]  m_out_level;
    logic [lrfq_pkg::STAMP_W-1:0]  m_out_stamp;
    logic [lrfq_pkg::LINE_W-1:0]   m_out_line;
    logic [lrfq_pkg::HANDLE_W-1:0] m_out_text;
    logic [lrfq_pkg::HANDLE_W-1:0] m_out_func;
    logic [lrfq_pkg::HANDLE_W-1:0] m_out_label;
    logic                          m_is_full;
    logic                          m_is_empty;

    // Predictor state
    logic                         drop_mode;
    logic [lrfq_pkg::RSIZE_W-1:0] size_reg;
    logic [lrfq_pkg::PTR_W-1:0]   rd_ptr;
    logic [lrfq_pkg::PTR_W-1:0]   wr_ptr;
    lrfq_pkg::record_t            slot_mem [lrfq_pkg::DEPTH];

    log_result_t pending_results[$];
    int error_count  = 0;
    int items_taken  = 0;
    int config_count = 0;
    int status_count [4];
    bit src_idle  = 1'b1;
    bit sink_idle = 1'b1;

    log_ring_fifo_drop_policy_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_in_level  (s_in_level),
        .s_in_stamp  (s_in_stamp),
        .s_in_line   (s_in_line),
        .s_in_text   (s_in_text),
        .s_in_func   (s_in_func),
        .s_in_label  (s_in_label),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_level (m_out_level),
        .m_out_stamp (m_out_stamp),
        .m_out_line  (m_out_line),
        .m_out_text  (m_out_text),
        .m_out_func  (m_out_func),
        .m_out_label (m_out_label),
        .m_is_full   (m_is_full),
        .m_is_empty  (m_is_empty)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("log_ring_fifo_drop_policy_core test failed");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [lrfq_pkg::SIZE_W-1:0] live_slots();
        if (size_reg < 2) return lrfq_pkg::SIZE_W'(2);
        if (size_reg > lrfq_pkg::DEPTH) return lrfq_pkg::SIZE_W'(lrfq_pkg::DEPTH);
        return lrfq_pkg::SIZE_W'(size_reg);
    endfunction

    // Pointers left past a shrunken ring also wrap to zero here.
    function automatic logic [lrfq_pkg::PTR_W-1:0] wrap_next(logic [lrfq_pkg::PTR_W-1:0] p);
        logic [lrfq_pkg::SIZE_W-1:0] n;
        n = lrfq_pkg::SIZE_W'(p) + lrfq_pkg::SIZE_W'(1);
        return (n >= live_slots()) ? '0 : n[lrfq_pkg::PTR_W-1:0];
    endfunction

    function automatic log_result_t predict_ring_op(log_entry_t e);
        log_result_t r;
        logic        do_write;
        r.status = lrfq_pkg::STS_OK;
        r.level  = '0;
        r.stamp  = '0;
        r.line   = '0;
        r.text   = '0;
        r.func   = '0;
        r.label  = '0;
        do_write = 1'b1;
        case (e.opcode)
            lrfq_pkg::OP_ENQ: begin
                if (wrap_next(wr_ptr) == rd_ptr) begin
                    if (drop_mode) begin
                        rd_ptr   = wrap_next(rd_ptr);
                        r.status = lrfq_pkg::STS_DROPPED;
                    end else begin
                        r.status = lrfq_pkg::STS_REFUSED;
                        do_write = 1'b0;
                    end
                end
                if (do_write) begin
                    slot_mem[wr_ptr].level = e.level;
                    slot_mem[wr_ptr].stamp = e.stamp;
                    if (e.line != 0) slot_mem[wr_ptr].line = e.line;
                    if (e.text != 0) slot_mem[wr_ptr].text = e.text;
                    if (e.func != 0) slot_mem[wr_ptr].func = e.func;
                    if (e.label != 0) slot_mem[wr_ptr].label = e.label;
                    wr_ptr = wrap_next(wr_ptr);
                end
            end
            lrfq_pkg::OP_DEQ: begin
                if (rd_ptr == wr_ptr) begin
                    r.status = lrfq_pkg::STS_EMPTY;
                end else begin
                    r.level = slot_mem[rd_ptr].level;
                    r.stamp = slot_mem[rd_ptr].stamp;
                    r.line  = slot_mem[rd_ptr].line;
                    r.text  = slot_mem[rd_ptr].text;
                    r.func  = slot_mem[rd_ptr].func;
                    r.label = slot_mem[rd_ptr].label;
                    rd_ptr  = wrap_next(rd_ptr);
                end
            end
            lrfq_pkg::OP_CLR: rd_ptr = wr_ptr;
            default: ;
        endcase
        r.full  = (wrap_next(wr_ptr) == rd_ptr);
        r.empty = (rd_ptr == wr_ptr);
        return r;
    endfunction

    // ---------------- checking ----------------

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : ring_monitor
        log_entry_t  got;
        log_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result transaction: expected none, actual status %h",
                             $time, m_status);
                end else begin
                    want = pending_results.pop_front();
                    status_count[want.status]++;
                    check_field("status", want.status, m_status);
                    check_field("out_level", want.level, m_out_level);
                    check_field("out_stamp", want.stamp, m_out_stamp);
                    check_field("out_line", want.line, m_out_line);
                    check_field("out_text", want.text, m_out_text);
                    check_field("out_func", want.func, m_out_func);
                    check_field("out_label", want.label, m_out_label);
                    check_field("is_full", want.full, m_is_full);
                    check_field("is_empty", want.empty, m_is_empty);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    lrfq_pkg::CFG_DROP_OLDEST: drop_mode = cfg_data[0];
                    lrfq_pkg::CFG_RING_SIZE:   size_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                got.opcode = s_opcode;
                got.level  = s_in_level;
                got.stamp  = s_in_stamp;
                got.line   = s_in_line;
                got.text   = s_in_text;
                got.func   = s_in_func;
                got.label  = s_in_label;
                pending_results.push_back(predict_ring_op(got));
                items_taken++;
            end
        end
    end

    // Result side back-pressure: ready and stall runs of random length, or always ready while the sink is not idle.
    initial begin : result_sink
        int hold;
        int r;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (!sink_idle) begin
                m_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_ready <= 1'b1;
                    hold = $urandom_range(0, 5);
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    m_ready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic int pick_gap();
        int r;
        if (!src_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Caller is at a rising edge; returns at the edge the transaction is taken.
    task automatic send_entry(log_entry_t e);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= e.opcode;
        s_in_level <= e.level;
        s_in_stamp <= e.stamp;
        s_in_line  <= e.line;
        s_in_text  <= e.text;
        s_in_func  <= e.func;
        s_in_label <= e.label;
        do @(posedge aclk); while (!s_ready);
    endtask

    // One edge first so the monitor has logged the last accepted transaction.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // drop_oldest is bit 0; upper data bits are noise the block must ignore.
    task automatic write_config(logic drop, logic [lrfq_pkg::CFG_DATA_W-1:0] size);
        cfg_wr_en <= 1'b1;
        cfg_index <= lrfq_pkg::CFG_DROP_OLDEST;
        cfg_data  <= {4'($urandom_range(0, 15)), drop};
        @(posedge aclk);
        cfg_index <= lrfq_pkg::CFG_RING_SIZE;
        cfg_data  <= size;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        config_count++;
    endtask

    function automatic log_entry_t make_entry(logic [lrfq_pkg::OPCODE_W-1:0] op,
                                              logic [lrfq_pkg::LEVEL_W-1:0] lvl,
                                              logic [lrfq_pkg::STAMP_W-1:0] stamp,
                                              logic [lrfq_pkg::LINE_W-1:0] line,
                                              logic [lrfq_pkg::HANDLE_W-1:0] text,
                                              logic [lrfq_pkg::HANDLE_W-1:0] func,
                                              logic [lrfq_pkg::HANDLE_W-1:0] label);
        log_entry_t e;
        e.opcode = op;
        e.level  = lvl;
        e.stamp  = stamp;
        e.line   = line;
        e.text   = text;
        e.func   = func;
        e.label  = label;
        return e;
    endfunction

    function automatic logic [lrfq_pkg::HANDLE_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return '0;
        if (r < 35) return '1;
        return $urandom;
    endfunction

    function automatic log_entry_t random_entry(int enq_pct);
        log_entry_t e;
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct) e.opcode = lrfq_pkg::OP_ENQ;
        else if (r < 95) e.opcode = lrfq_pkg::OP_DEQ;
        else if (r < 98) e.opcode = lrfq_pkg::OP_CLR;
        else e.opcode = OP_UNUSED;
        e.level = lrfq_pkg::LEVEL_W'($urandom_range(0, 7));
        e.stamp = pick_word();
        e.line  = lrfq_pkg::LINE_W'(pick_word());
        e.text  = pick_word();
        e.func  = pick_word();
        e.label = pick_word();
        return e;
    endfunction

    // ---------------- tests ----------------

    task automatic test_reset_state();
        send_entry(make_entry(lrfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0));
        send_entry(make_entry(OP_UNUSED, 7, '1, '1, '1, '1, '1));
        send_entry(make_entry(lrfq_pkg::OP_ENQ, 7, '1, '1, '1, '1, '1));
        send_entry(make_entry(lrfq_pkg::OP_ENQ, 0, 0, 0, 0, 0, 0));
        send_entry(make_entry(lrfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0));
        send_entry(make_entry(lrfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0));
        send_entry(make_entry(lrfq_pkg::OP_CLR, 0, 0, 0, 0, 0, 0));
        wait_idle();
    endtask

    // Ring shrunk to two slots with both pointers outside it; then fill and refuse.
    // The second record has zero line and handles, so slot 0 keeps its old ones.
    task automatic test_refuse_when_full();
        write_config(1'b0, 5'd2);
        send_entry(make_entry(lrfq_pkg::OP_ENQ, 3, 32'h1234_5678, 16'd100,
                              32'hA1, 32'hB2, 32'hC3));
        send_entry(make_entry(lrfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0));
        send_entry(make_entry(lrfq_pkg::OP_ENQ, 5, 32'h0000_0042, 0, 0, 0, 0));
        send_entry(make_entry(lrfq_pkg::OP_ENQ, 6, 32'hDEAD_BEEF, 16'd7,
                              32'h11, 32'h22, 32'h33));
        send_entry(make_entry(lrfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0));
        wait_idle();
    endtask

    task automatic test_drop_oldest();
        write_config(1'b1, 5'd3);
        send_entry(make_entry(lrfq_pkg::OP_ENQ, 1, 32'h0000_1111, 16'd11, 32'h1, 32'h2, 32'h3));
        send_entry(make_entry(lrfq_pkg::OP_ENQ, 2, 32'h0000_2222, 16'd22, 32'h4, 32'h5, 32'h6));
        send_entry(make_entry(lrfq_pkg::OP_ENQ, 4, 32'h0000_3333, 16'd33, 32'h7, 32'h8, 32'h9));
        send_entry(make_entry(lrfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0));
        send_entry(make_entry(lrfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0));
        send_entry(make_entry(lrfq_pkg::OP_DEQ, 0, 0, 0, 0, 0, 0));
        wait_idle();
    endtask

    // Each phase alternates fill-biased and drain-biased stretches so the ring
    // regularly reaches full and empty under each policy and size.
    task automatic test_random_phases();
        logic                            drops [8] = '{0, 1, 0, 1, 1, 0, 1, 0};
        logic [lrfq_pkg::CFG_DATA_W-1:0] sizes [8] = '{2, 2, 16, 16, 0, 1, 31, 17};
        logic                            drop;
        logic [lrfq_pkg::CFG_DATA_W-1:0] size;
        int                              enq_pct;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p < 8) begin
                drop = drops[p];
                size = sizes[p];
            end else begin
                drop = 1'($urandom_range(0, 1));
                size = lrfq_pkg::CFG_DATA_W'($urandom_range(0, 31));
            end
            src_idle  = !(p == 2 || p == 7);
            sink_idle = src_idle;
            write_config(drop, size);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                enq_pct = ((i / 24) % 2 == 0) ? 85 : 35;
                send_entry(random_entry(enq_pct));
            end
            wait_idle();
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial begin
        drop_mode = 1'b0;
        size_reg  = lrfq_pkg::RSIZE_W'(lrfq_pkg::RING_SIZE_RST);
        rd_ptr    = '0;
        wr_ptr    = '0;
        for (int i = 0; i < lrfq_pkg::DEPTH; i++) slot_mem[i] = '0;
        for (int i = 0; i < 4; i++) status_count[i] = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_refuse_when_full();
        test_drop_oldest();
        test_random_phases();
        wait_idle();

        $display("Checked %0d transactions over %0d policy/size settings.",
                 items_taken, config_count);
        $display("Outcomes: %0d ok, %0d refused, %0d oldest dropped, %0d empty.",
                 status_count[lrfq_pkg::STS_OK], status_count[lrfq_pkg::STS_REFUSED],
                 status_count[lrfq_pkg::STS_DROPPED], status_count[lrfq_pkg::STS_EMPTY]);
        if (error_count == 0) begin
            $display("log_ring_fifo_drop_policy_core test passed");
        end else begin
            $display("log_ring_fifo_drop_policy_core test failed");
        end
        $finish;
    end

endmodule
